// ===== rtl/qsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qsm_pkg;

  localparam int unsigned GainW   = 15;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned WordW   = 6;
  localparam int unsigned HeldW   = 5;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [GainW-1:0] GainQpskReset  = 15'd23170;
  localparam logic [GainW-1:0] GainQam16Reset = 15'd10362;
  localparam logic [GainW-1:0] GainQam64Reset = 15'd5056;

  typedef enum logic [1:0] {
    MOD_QPSK  = 2'd0,
    MOD_QAM16 = 2'd1,
    MOD_QAM64 = 2'd2
  } qsm_mod_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 3'd0,
    CFG_NORMALIZE  = 3'd1,
    CFG_GAIN_QPSK  = 3'd2,
    CFG_GAIN_QAM16 = 3'd3,
    CFG_GAIN_QAM64 = 3'd4
  } qsm_cfg_idx_e;

  typedef struct packed {
    qsm_mod_e          modulation;
    logic [WordW-1:0]  word;
    logic              length_error;
    logic              frame_last;
  } qsm_group_t;

  typedef struct packed {
    logic             normalize;
    logic [GainW-1:0] gain_qpsk;
    logic [GainW-1:0] gain_qam16;
    logic [GainW-1:0] gain_qam64;
  } qsm_scale_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/qsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qsm_in_if;
  logic valid;
  logic ready;
  logic bit_in;
  logic frame_end;

  modport source (output valid, output bit_in, output frame_end, input ready);
  modport sink (input valid, input bit_in, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/qsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] i_value;
  logic signed [15:0] q_value;
  logic               length_error;
  logic               frame_last;

  modport source (output valid, output i_value, output q_value, output length_error,
                  output frame_last, input ready);
  modport sink (input valid, input i_value, input q_value, input length_error,
                input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/qam_symbol_mapper_unit.sv =====
// Pipeline: two register stages, one in the bit collector register and one in the
// level/scale result register. A group is registered in the collector when the bit that
// completes it (or ends its frame) is taken, then moves on once the result register can take it.
// Throughput: one bit per cycle, sustained unless a low out_o.ready stalls the input.
// Reset: clears the partial group and both valid flags; config registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module qam_symbol_mapper_unit
  import qsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [GainW-1:0]   cfg_data_i,
  qsm_in_if.sink                  in_i,
  qsm_out_if.source               out_o
);

  logic [1:0]       mode_q;
  logic             normalize_q;
  logic [GainW-1:0] gain_qpsk_q;
  logic [GainW-1:0] gain_qam16_q;
  logic [GainW-1:0] gain_qam64_q;

  qsm_scale_cfg_t scale_cfg;
  logic           grp_valid;
  logic           grp_ready;
  qsm_group_t     grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MOD_QPSK;
      normalize_q  <= 1'b0;
      gain_qpsk_q  <= GainQpskReset;
      gain_qam16_q <= GainQam16Reset;
      gain_qam64_q <= GainQam64Reset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        CFG_NORMALIZE:  normalize_q  <= cfg_data_i[0];
        CFG_GAIN_QPSK:  gain_qpsk_q  <= cfg_data_i;
        CFG_GAIN_QAM16: gain_qam16_q <= cfg_data_i;
        CFG_GAIN_QAM64: gain_qam64_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scale_cfg.normalize  = normalize_q;
  assign scale_cfg.gain_qpsk  = gain_qpsk_q;
  assign scale_cfg.gain_qam16 = gain_qam16_q;
  assign scale_cfg.gain_qam64 = gain_qam64_q;

  qsm_collector u_collector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_i        (in_i),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  qsm_level_scaler u_level_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_i       (grp),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/qsm_collector.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qsm_collector
  import qsm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] mode_i,
  qsm_in_if.sink          in_i,
  output logic            grp_valid_o,
  input  wire logic       grp_ready_i,
  output qsm_group_t      grp_o
);

  logic [HeldW-1:0]  held_bits_q, held_bits_d;
  logic [CountW-1:0] held_count_q, held_count_d;
  logic              grp_valid_q, grp_valid_d;
  qsm_group_t        grp_q, grp_d;

  qsm_mod_e          modulation;
  logic [CountW-1:0] group_size;
  logic [CountW-1:0] count;
  logic [WordW-1:0]  word;
  logic              emit;
  logic              produce;
  logic              in_xfer;

  always_comb begin
    case (mode_i)
      MOD_QPSK: begin
        modulation = MOD_QPSK;
        group_size = 3'd2;
      end
      MOD_QAM16: begin
        modulation = MOD_QAM16;
        group_size = 3'd4;
      end
      default: begin
        modulation = MOD_QAM64;
        group_size = 3'd6;
      end
    endcase
  end

  assign word    = {held_bits_q, in_i.bit_in};
  assign count   = held_count_q + 3'd1;
  assign emit    = (count >= group_size);
  assign produce = emit || in_i.frame_end;

  assign in_i.ready = !grp_valid_q || grp_ready_i;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    held_bits_d  = held_bits_q;
    held_count_d = held_count_q;
    grp_valid_d  = grp_valid_q;
    grp_d        = grp_q;
    if (grp_valid_q && grp_ready_i) begin
      grp_valid_d = 1'b0;
    end
    if (in_xfer) begin
      if (produce) begin
        held_bits_d             = '0;
        held_count_d            = '0;
        grp_valid_d             = 1'b1;
        grp_d.modulation        = modulation;
        grp_d.word              = word;
        grp_d.length_error      = !emit;
        grp_d.frame_last        = in_i.frame_end;
      end else begin
        held_bits_d  = word[HeldW-1:0];
        held_count_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bits_q  <= '0;
      held_count_q <= '0;
      grp_valid_q  <= 1'b0;
    end else begin
      held_bits_q  <= held_bits_d;
      held_count_q <= held_count_d;
      grp_valid_q  <= grp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

endmodule

`default_nettype wire

// ===== rtl/qsm_level_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qsm_level_scaler
  import qsm_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qsm_scale_cfg_t cfg_i,
  input  wire logic           grp_valid_i,
  output logic                grp_ready_o,
  input  wire qsm_group_t     grp_i,
  qsm_out_if.source           out_o
);

  function automatic logic signed [ValueW-1:0] scale_level(
    input logic             neg,
    input logic [2:0]       mag,
    input logic [GainW-1:0] gain,
    input logic             normalize
  );
    logic [GainW+2:0]  prod;
    logic [GainW-1:0]  r;
    logic [ValueW-1:0] ext;
    prod = ({{(GainW){1'b0}}, mag} * {3'b000, gain}) + 18'd4;
    if (normalize) begin
      r = prod[GainW+2:3];
    end else begin
      r = {mag, 12'd0};
    end
    ext = {1'b0, r};
    return neg ? $signed(-ext) : $signed(ext);
  endfunction

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] i_value_q, i_value_d;
  logic signed [ValueW-1:0] q_value_q, q_value_d;
  logic                     length_error_q, length_error_d;
  logic                     frame_last_q, frame_last_d;

  logic             i_neg, q_neg;
  logic [2:0]       i_mag, q_mag;
  logic [GainW-1:0] gain;
  logic             grp_xfer;

  always_comb begin
    case (grp_i.modulation)
      MOD_QPSK: begin
        i_neg = !grp_i.word[1];
        i_mag = 3'd1;
        q_neg = !grp_i.word[0];
        q_mag = 3'd1;
        gain  = cfg_i.gain_qpsk;
      end
      MOD_QAM16: begin
        i_neg = !grp_i.word[3];
        i_mag = grp_i.word[2] ? 3'd3 : 3'd1;
        q_neg = !grp_i.word[1];
        q_mag = grp_i.word[0] ? 3'd3 : 3'd1;
        gain  = cfg_i.gain_qam16;
      end
      default: begin
        i_neg = !grp_i.word[5];
        i_mag = {grp_i.word[5] ? grp_i.word[4:3] : ~grp_i.word[4:3], 1'b1};
        q_neg = !grp_i.word[2];
        q_mag = {grp_i.word[2] ? grp_i.word[1:0] : ~grp_i.word[1:0], 1'b1};
        gain  = cfg_i.gain_qam64;
      end
    endcase
  end

  assign grp_ready_o = !out_valid_q || out_o.ready;
  assign grp_xfer    = grp_valid_i && grp_ready_o;

  always_comb begin
    out_valid_d    = out_valid_q;
    i_value_d      = i_value_q;
    q_value_d      = q_value_q;
    length_error_d = length_error_q;
    frame_last_d   = frame_last_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (grp_xfer) begin
      out_valid_d    = 1'b1;
      length_error_d = grp_i.length_error;
      frame_last_d   = grp_i.frame_last;
      if (grp_i.length_error) begin
        i_value_d = '0;
        q_value_d = '0;
      end else begin
        i_value_d = scale_level(i_neg, i_mag, gain, cfg_i.normalize);
        q_value_d = scale_level(q_neg, q_mag, gain, cfg_i.normalize);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_value_q      <= i_value_d;
    q_value_q      <= q_value_d;
    length_error_q <= length_error_d;
    frame_last_q   <= frame_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.i_value      = i_value_q;
  assign out_o.q_value      = q_value_q;
  assign out_o.length_error = length_error_q;
  assign out_o.frame_last   = frame_last_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

import qsm_pkg::*;

typedef struct packed {
  logic signed [ValueW-1:0] i_value;
  logic signed [ValueW-1:0] q_value;
  logic                     length_error;
  logic                     frame_last;
} symbol_t;

class symbol_tracker;
  logic [1:0]       mode;
  logic             normalize;
  logic [GainW-1:0] gain_qpsk;
  logic [GainW-1:0] gain_qam16;
  logic [GainW-1:0] gain_qam64;
  logic [HeldW-1:0] held_bits;
  int unsigned      held_count;
  symbol_t          pending_symbols[$];
  int unsigned      mismatches;

  function new();
    mode       = MOD_QPSK;
    normalize  = 1'b0;
    gain_qpsk  = GainQpskReset;
    gain_qam16 = GainQam16Reset;
    gain_qam64 = GainQam64Reset;
    held_bits  = '0;
    held_count = 0;
    mismatches = 0;
  endfunction

  function int unsigned group_bits();
    case (mode)
      MOD_QPSK:  return 2;
      MOD_QAM16: return 4;
      default:   return 6;
    endcase
  endfunction

  function void write_reg(qsm_cfg_idx_e idx, logic [GainW-1:0] data);
    case (idx)
      CFG_MODE:       mode = data[1:0];
      CFG_NORMALIZE:  normalize = data[0];
      CFG_GAIN_QPSK:  gain_qpsk = data;
      CFG_GAIN_QAM16: gain_qam16 = data;
      CFG_GAIN_QAM64: gain_qam64 = data;
      default: ;
    endcase
  endfunction

  function logic signed [ValueW-1:0] level_to_q12(int lvl, logic [GainW-1:0] gain);
    int mag;
    int r;
    mag = (lvl < 0) ? -lvl : lvl;
    if (normalize) begin
      r = (mag * int'(gain) + 4) >> 3;
    end else begin
      r = mag * 4096;
    end
    return (lvl < 0) ? ValueW'(-r) : ValueW'(r);
  endfunction

  function void take_bit(logic bit_val, logic end_val);
    logic [WordW-1:0] word;
    int unsigned      count;
    int               ilev;
    int               qlev;
    logic [GainW-1:0] gain;
    symbol_t          sym;
    word  = {held_bits, bit_val};
    count = held_count + 1;
    if (count >= group_bits()) begin
      case (group_bits())
        2: begin
          ilev = word[1] ? 1 : -1;
          qlev = word[0] ? 1 : -1;
          gain = gain_qpsk;
        end
        4: begin
          ilev = (word[3] ? 1 : -1) * (word[2] ? 3 : 1);
          qlev = (word[1] ? 1 : -1) * (word[0] ? 3 : 1);
          gain = gain_qam16;
        end
        default: begin
          ilev = 2 * int'(word[5:3]) - 7;
          qlev = 2 * int'(word[2:0]) - 7;
          gain = gain_qam64;
        end
      endcase
      sym.i_value      = level_to_q12(ilev, gain);
      sym.q_value      = level_to_q12(qlev, gain);
      sym.length_error = 1'b0;
      sym.frame_last   = end_val;
      pending_symbols.insert(pending_symbols.size(), sym);
      held_bits  = '0;
      held_count = 0;
    end else if (end_val) begin
      sym.i_value      = '0;
      sym.q_value      = '0;
      sym.length_error = 1'b1;
      sym.frame_last   = 1'b1;
      pending_symbols.insert(pending_symbols.size(), sym);
      held_bits  = '0;
      held_count = 0;
    end else begin
      held_bits  = word[HeldW-1:0];
      held_count = count;
    end
  endfunction

  function void check_symbol(symbol_t got);
    symbol_t want;
    if (pending_symbols.size() == 0) begin
      mismatches++;
      $display("%0t: expected no symbol, got i=%0d q=%0d err=%b last=%b", $time,
               got.i_value, got.q_value, got.length_error, got.frame_last);
      return;
    end
    want = pending_symbols.pop_front();
    if (got.i_value !== want.i_value) begin
      mismatches++;
      $display("%0t: i_value expected %0d got %0d", $time, want.i_value, got.i_value);
    end
    if (got.q_value !== want.q_value) begin
      mismatches++;
      $display("%0t: q_value expected %0d got %0d", $time, want.q_value, got.q_value);
    end
    if (got.length_error !== want.length_error) begin
      mismatches++;
      $display("%0t: length_error expected %b got %b", $time, want.length_error,
               got.length_error);
    end
    if (got.frame_last !== want.frame_last) begin
      mismatches++;
      $display("%0t: frame_last expected %b got %b", $time, want.frame_last, got.frame_last);
    end
  endfunction
endclass

module tb;
  localparam int unsigned DirectedItems = 25;
  localparam int unsigned Phases        = 8;
  localparam int unsigned PhaseItems    = 175;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned QuietLimit    = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [GainW-1:0]   cfg_data_i;

  qsm_in_if  in_if ();
  qsm_out_if out_if ();

  qam_symbol_mapper_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  symbol_tracker tracker;
  int unsigned   items_sent = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   holds_asked = 0;
  int unsigned   holds_granted = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
        out_if.ready  <= 1'b0;
        hold_left     <= HoldCycles;
        holds_granted <= holds_granted + 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    symbol_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tracker.take_bit(in_if.bit_in, in_if.frame_end);
      end
      if (out_if.valid && out_if.ready) begin
        got.i_value      = out_if.i_value;
        got.q_value      = out_if.q_value;
        got.length_error = out_if.length_error;
        got.frame_last   = out_if.frame_last;
        tracker.check_symbol(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic bit_val, input logic end_val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.bit_in    <= bit_val;
    in_if.frame_end <= end_val;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_bits(input logic [5:0] bits, input int unsigned n, input logic closes);
    for (int k = n - 1; k >= 0; k--) begin
      send_item(bits[k], closes && (k == 0));
    end
  endtask

  task automatic send_frame(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_item(1'($urandom_range(1)), k == n - 1);
    end
  endtask

  // hold the input idle until every symbol is out and the pipeline has settled
  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_symbols.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input qsm_cfg_idx_e idx, input logic [GainW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    tracker.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [GainW-1:0] pick_gain(input int unsigned p);
    if (p == 1 || p == 6) return '1;
    if (p == 4) return '0;
    return GainW'($urandom_range(32767));
  endfunction

  task automatic run_phase(input int unsigned p);
    int unsigned goal;
    int unsigned grp;
    int unsigned pick;
    goal = DirectedItems + (p + 1) * PhaseItems;
    wait_until_drained();
    cfg_write(CFG_MODE, GainW'(p % 4));
    cfg_write(CFG_NORMALIZE, GainW'(p[0] ^ p[2]));
    cfg_write(CFG_GAIN_QPSK, pick_gain(p));
    cfg_write(CFG_GAIN_QAM16, pick_gain(p));
    cfg_write(CFG_GAIN_QAM64, pick_gain(p));
    cfg_we_i <= 1'b0;
    case (p % 4)
      0: begin src_idle_pct = 0;  stall_pct <= 0;  end
      1: begin src_idle_pct = 74; stall_pct <= 0;  end
      2: begin src_idle_pct = 0;  stall_pct <= 74; end
      default: begin src_idle_pct = 6; stall_pct <= 6; end
    endcase
    if (p == 4) holds_asked <= holds_asked + 1;
    grp = tracker.group_bits();
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame(grp * $urandom_range(1, 6));
      end else if (pick < 92) begin
        send_frame(grp * $urandom_range(0, 5) + $urandom_range(1, grp - 1));
      end else begin
        repeat (8) send_item(1'($urandom_range(1)), $urandom_range(7) == 0);
      end
    end
    // leave a partial group behind so the next mode change lands mid-group
    if ($urandom_range(1) == 1) begin
      repeat ($urandom_range(1, grp - 1)) send_item(1'($urandom_range(1)), 1'b0);
    end
  endtask

  initial begin
    tracker         = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_MODE;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.bit_in    = 1'b0;
    in_if.frame_end = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_bits(6'b000001, 2, 1'b0);
    send_bits(6'b000010, 2, 1'b1);
    send_item(1'b1, 1'b1);

    wait_until_drained();
    cfg_write(CFG_MODE, GainW'(MOD_QAM16));
    cfg_write(CFG_NORMALIZE, GainW'(1));
    cfg_we_i <= 1'b0;
    send_bits(6'b000110, 4, 1'b1);

    wait_until_drained();
    cfg_write(CFG_MODE, GainW'(MOD_QAM64));
    cfg_write(CFG_GAIN_QAM64, '1);
    cfg_we_i <= 1'b0;
    send_bits(6'b111111, 6, 1'b0);
    send_bits(6'b000000, 6, 1'b1);
    send_bits(6'b000101, 3, 1'b0);

    wait_until_drained();
    cfg_write(CFG_MODE, GainW'(MOD_QPSK));
    cfg_we_i <= 1'b0;
    send_item(1'b1, 1'b1);

    for (int unsigned p = 0; p < Phases; p++) begin
      run_phase(p);
    end

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_symbols.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/qsm_pkg.sv
rtl/qsm_in_if.sv
rtl/qsm_out_if.sv
rtl/qsm_collector.sv
rtl/qsm_level_scaler.sv
rtl/qam_symbol_mapper_unit.sv
test/tb.sv
